// ===== rtl/cft_pkg.sv =====
package cft_pkg;

	localparam int WIPER_W   = 9;
	localparam int CURRENT_W = 24;
	localparam int TOL_W     = 23;
	localparam int STATUS_W  = 3;

	// Wiper travel limits; the wiper stays strictly between LOW and HIGH
	localparam int WIPER_LOW  = 0;
	localparam int WIPER_HIGH = 256;
	localparam int WIPER_MID  = 128;

	// Coarse-to-fine step sizes
	localparam int NUM_STEPS = 3;
	localparam int STEP_IDX_W = 2;
	localparam logic [6:0] STEP_SIZE [NUM_STEPS] = '{7'd100, 7'd10, 7'd1};

	// Register map: index taken from paddr[2]
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef enum logic {
		REG_TARGET    = 1'b0,
		REG_TOLERANCE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_MOVED = 2'd2
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_AWAIT     = 3'd0,
		ST_WITHIN    = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_READ_ERR  = 3'd3,
		ST_IGNORED   = 3'd4
	} status_t;

	typedef enum logic {
		MODE_START   = 1'b0,
		MODE_MEASURE = 1'b1
	} mode_t;

	typedef struct packed {
		logic                write_wiper;
		logic [WIPER_W-1:0]  wiper_value;
		status_t             status;
	} result_t;

endpackage

// ===== rtl/coarse_fine_current_trimmer.sv =====
// Coarse-to-fine current trimmer. A start item (mode 0) puts the wiper at
// mid-scale and returns a wiper write. Each measurement item (mode 1) is
// compared against target_current: within current_tolerance the search ends
// with status 1; otherwise the step (100, 10, 1) is refined after an
// overshoot and the next in-range step toward the target is returned as a
// wiper write, or status 2 once no step size is left. A failed reading
// returns status 3 and a measurement while idle returns status 4. Every
// item gives exactly one result. Throughput is one item per clock unless the
// output stalls: an item is registered in the input stage while the compare
// and the three candidate steps are evaluated, then lands in the output
// register, which drives out_valid. The input side stalls only while the
// output register holds a result that is itself stalled.
// Registers (APB, 32-bit): 0x0 target_current (24-bit signed),
// 0x4 current_tolerance (23-bit unsigned); write them only while idle.
module coarse_fine_current_trimmer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input items
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    mode,
	input  logic signed [cft_pkg::CURRENT_W-1:0]    measured_current,
	input  logic                                    reading_ok,
	// result items
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    write_wiper,
	output logic [cft_pkg::WIPER_W-1:0]             wiper_value,
	output logic [cft_pkg::STATUS_W-1:0]            status,
	// configuration
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [cft_pkg::PADDR_W-1:0]             paddr,
	input  logic [cft_pkg::PDATA_W-1:0]             pwdata,
	output logic [cft_pkg::PDATA_W-1:0]             prdata,
	output logic                                    pready
);

	localparam int NW = cft_pkg::WIPER_W + 2;   // signed width for candidate positions
	localparam logic signed [NW-1:0] W_LOW  = NW'(cft_pkg::WIPER_LOW);
	localparam logic signed [NW-1:0] W_HIGH = NW'(cft_pkg::WIPER_HIGH);
	localparam logic [cft_pkg::WIPER_W-1:0] W_MID = cft_pkg::WIPER_W'(cft_pkg::WIPER_MID);
	localparam logic MID_IN_RANGE = (cft_pkg::WIPER_MID > cft_pkg::WIPER_LOW)
		&& (cft_pkg::WIPER_MID < cft_pkg::WIPER_HIGH);
	localparam logic [cft_pkg::STEP_IDX_W-1:0] STEP_DONE =
		cft_pkg::STEP_IDX_W'(cft_pkg::NUM_STEPS);

	// ---------------- configuration registers ----------------
	logic signed [cft_pkg::CURRENT_W-1:0] target_q;
	logic [cft_pkg::TOL_W-1:0]            tol_q;
	logic                                 cfg_wr;
	cft_pkg::reg_idx_t                    reg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = cft_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			tol_q    <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				cft_pkg::REG_TARGET:    target_q <= pwdata[cft_pkg::CURRENT_W-1:0];
				cft_pkg::REG_TOLERANCE: tol_q    <= pwdata[cft_pkg::TOL_W-1:0];
				default:                target_q <= target_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cft_pkg::REG_TARGET:
				prdata = {{(cft_pkg::PDATA_W-cft_pkg::CURRENT_W){1'b0}}, target_q};
			cft_pkg::REG_TOLERANCE:
				prdata = {{(cft_pkg::PDATA_W-cft_pkg::TOL_W){1'b0}}, tol_q};
			default:
				prdata = '0;
		endcase
	end

	// ---------------- input stage ----------------
	logic                                 valid_s1;
	logic                                 mode_s1;
	logic signed [cft_pkg::CURRENT_W-1:0] cur_s1;
	logic                                 ok_s1;
	logic                                 in_accept;
	logic                                 advance;
	logic                                 out_valid_q;
	cft_pkg::result_t                     res_q;

	// item leaves s1 whenever the output register is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1 <= mode;
			cur_s1  <= measured_current;
			ok_s1   <= reading_ok;
		end
	end

	// ---------------- search state ----------------
	cft_pkg::phase_t                  phase_q, phase_d;
	logic [cft_pkg::WIPER_W-1:0]      pos_q, pos_d;
	logic [cft_pkg::STEP_IDX_W-1:0]   step_q, step_d;
	logic                             up_q, up_d;
	cft_pkg::result_t                 res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cft_pkg::PH_IDLE;
			pos_q   <= W_MID;
			step_q  <= '0;
			up_q    <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			step_q  <= step_d;
			up_q    <= up_d;
		end
	end

	// ---------------- decision logic ----------------
	logic signed [cft_pkg::CURRENT_W:0]   diff;
	logic [cft_pkg::CURRENT_W:0]          abs_diff;
	logic                                 in_tol;
	logic                                 overshoot;
	logic                                 move_up;
	logic [cft_pkg::STEP_IDX_W-1:0]       step_eff;
	logic signed [NW-1:0]                 cand   [cft_pkg::NUM_STEPS];
	logic [cft_pkg::NUM_STEPS-1:0]        cand_ok;

	assign diff      = {cur_s1[cft_pkg::CURRENT_W-1], cur_s1}
		- {target_q[cft_pkg::CURRENT_W-1], target_q};
	assign abs_diff  = diff[cft_pkg::CURRENT_W] ? (cft_pkg::CURRENT_W+1)'(-diff)
		: (cft_pkg::CURRENT_W+1)'(diff);
	assign in_tol    = abs_diff <= {2'b00, tol_q};
	assign overshoot = up_q ? (cur_s1 >= target_q) : (cur_s1 <= target_q);
	assign move_up   = cur_s1 < target_q;
	assign step_eff  = (phase_q == cft_pkg::PH_MOVED && overshoot && step_q != STEP_DONE)
		? step_q + 1'b1 : step_q;

	// one candidate per step size, evaluated in parallel
	always_comb begin
		for (int k = 0; k < cft_pkg::NUM_STEPS; k++) begin
			cand[k] = move_up
				? $signed({2'b00, pos_q}) + $signed(NW'(cft_pkg::STEP_SIZE[k]))
				: $signed({2'b00, pos_q}) - $signed(NW'(cft_pkg::STEP_SIZE[k]));
			cand_ok[k] = (cand[k] > W_LOW) && (cand[k] < W_HIGH)
				&& (cft_pkg::STEP_IDX_W'(k) >= step_eff);
		end
	end

	always_comb begin
		logic found;
		found   = 1'b0;
		phase_d = phase_q;
		pos_d   = pos_q;
		step_d  = step_q;
		up_d    = up_q;
		res_d   = '{write_wiper: 1'b0, wiper_value: pos_q, status: cft_pkg::ST_IGNORED};

		if (mode_s1 == cft_pkg::MODE_START) begin
			phase_d = cft_pkg::PH_FIRST;
			pos_d   = W_MID;
			step_d  = '0;
			up_d    = 1'b0;
			res_d   = '{write_wiper: MID_IN_RANGE, wiper_value: W_MID,
				status: cft_pkg::ST_AWAIT};
		end else if (phase_q == cft_pkg::PH_IDLE) begin
			res_d.status = cft_pkg::ST_IGNORED;
		end else if (!ok_s1) begin
			phase_d      = cft_pkg::PH_IDLE;
			res_d.status = cft_pkg::ST_READ_ERR;
		end else if (in_tol) begin
			phase_d      = cft_pkg::PH_IDLE;
			res_d.status = cft_pkg::ST_WITHIN;
		end else begin
			// first usable step at or finer than the current one
			for (int k = 0; k < cft_pkg::NUM_STEPS; k++) begin
				if (cand_ok[k] && !found) begin
					found  = 1'b1;
					pos_d  = cand[k][cft_pkg::WIPER_W-1:0];
					step_d = cft_pkg::STEP_IDX_W'(k);
				end
			end
			if (found) begin
				phase_d = cft_pkg::PH_MOVED;
				up_d    = move_up;
				res_d   = '{write_wiper: 1'b1, wiper_value: pos_d,
					status: cft_pkg::ST_AWAIT};
			end else begin
				phase_d      = cft_pkg::PH_IDLE;
				step_d       = STEP_DONE;
				res_d.status = cft_pkg::ST_EXHAUSTED;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign write_wiper = res_q.write_wiper;
	assign wiper_value = res_q.wiper_value;
	assign status      = res_q.status;

	// ---------------- assertions ----------------
	// a start item always lands at mid-scale awaiting a reading
	a_start_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1 == cft_pkg::MODE_START) |=>
		(out_valid && wiper_value == W_MID && status == cft_pkg::ST_AWAIT))
		else $error("start item did not command mid-scale");

	// a commanded wiper stays strictly inside the travel range
	a_wiper_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_wiper && mode_s1 == cft_pkg::MODE_MEASURE && status == cft_pkg::ST_AWAIT
			&& wiper_value != W_MID) |->
		($signed({2'b00, wiper_value}) > W_LOW && $signed({2'b00, wiper_value}) < W_HIGH))
		else $error("wiper command out of range");

	// a finishing result leaves the search idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == cft_pkg::ST_WITHIN || status == cft_pkg::ST_EXHAUSTED
			|| status == cft_pkg::ST_READ_ERR)) |-> (phase_q == cft_pkg::PH_IDLE))
		else $error("search not idle after finish");

	// a move always uses a real step size
	a_move_step: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cft_pkg::PH_MOVED) |-> (step_q != STEP_DONE))
		else $error("moved with no step size left");

	// stalled input only while the output register is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

endmodule

// ===== verif/tb.sv =====
module tb;

	// Search steps, coarse to fine
	localparam int TRIM_STEP [3] = '{100, 10, 1};

	// Current extremes, 1/256 mA
	localparam logic [cft_pkg::CURRENT_W-1:0] CUR_MIN = 24'h800000;
	localparam logic [cft_pkg::CURRENT_W-1:0] CUR_MAX = 24'h7FFFFF;
	localparam longint CUR_LO = -8388608;
	localparam longint CUR_HI = 8388607;

	// Settings for the directed part: 16 mA target, 0.25 mA tolerance
	localparam logic [cft_pkg::CURRENT_W-1:0] TGT_DIR = 24'd4096;
	localparam logic [cft_pkg::CURRENT_W-1:0] TOL_DIR = 24'd64;

	localparam int DIR_N = 26;
	localparam int NUM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 222;
	// Chance out of 16 of an idle burst starting, per config phase
	localparam int GAP_ODDS [NUM_PHASES] = '{3, 6, 0, 10, 2, 5, 0};

	typedef struct packed {
		logic                          md;
		logic [cft_pkg::CURRENT_W-1:0] cur;
		logic                          ok;
		bit                            typed;
		cft_pkg::result_t              want;
	} dir_row_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_stall;
	logic                                 mode;
	logic signed [cft_pkg::CURRENT_W-1:0] measured_current;
	logic                                 reading_ok;
	logic                                 out_valid;
	logic                                 out_stall;
	logic                                 write_wiper;
	logic [cft_pkg::WIPER_W-1:0]          wiper_value;
	logic [cft_pkg::STATUS_W-1:0]         status;
	logic                                 psel;
	logic                                 penable;
	logic                                 pwrite;
	logic [cft_pkg::PADDR_W-1:0]          paddr;
	logic [cft_pkg::PDATA_W-1:0]          pwdata;
	logic [cft_pkg::PDATA_W-1:0]          prdata;
	logic                                 pready;

	// Our own copy of the trimmer state and its two registers
	cft_pkg::phase_t                      trim_phase = cft_pkg::PH_IDLE;
	logic [cft_pkg::WIPER_W-1:0]          trim_pos = cft_pkg::WIPER_W'(cft_pkg::WIPER_MID);
	int                                   trim_sel = 0;
	logic                                 trim_up = 1'b0;
	logic signed [cft_pkg::CURRENT_W-1:0] cfg_target = '0;
	logic [cft_pkg::TOL_W-1:0]            cfg_tol = '0;

	cft_pkg::result_t  trim_exp [$];   // predicted wiper results, oldest first
	cft_pkg::result_t  want;
	dir_row_t          dir_tab [DIR_N];
	int                errs = 0;
	int                n_items = 0;    // items that did more than get ignored
	int                gap_odds = 0;
	int                stall_left = 0;

	coarse_fine_current_trimmer u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.measured_current (measured_current),
		.reading_ok       (reading_ok),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.write_wiper      (write_wiper),
		.wiper_value      (wiper_value),
		.status           (status),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cft_pkg::result_t trim_result(input logic wr,
			input logic [cft_pkg::WIPER_W-1:0] val, input cft_pkg::status_t st);
		cft_pkg::result_t r;
		r.write_wiper = wr;
		r.wiper_value = val;
		r.status = st;
		return r;
	endfunction

	function automatic dir_row_t row(input logic md, input logic [cft_pkg::CURRENT_W-1:0] cur,
			input logic ok, input bit typed, input logic wr,
			input logic [cft_pkg::WIPER_W-1:0] val, input cft_pkg::status_t st);
		dir_row_t d;
		d.md = md;
		d.cur = cur;
		d.ok = ok;
		d.typed = typed;
		d.want = trim_result(wr, val, st);
		return d;
	endfunction

	// Advances the trimmer copy by one item and returns the result it gives
	function automatic cft_pkg::result_t trim_next(input logic md,
			input logic signed [cft_pkg::CURRENT_W-1:0] cur, input logic ok);
		longint dev;
		logic   up;
		logic   over;
		int     nxt;
		if (md == cft_pkg::MODE_START) begin
			// restart from mid-scale, busy or not; current and reading flag don't matter
			trim_pos = cft_pkg::WIPER_W'(cft_pkg::WIPER_MID);
			trim_sel = 0;
			trim_up = 1'b0;
			trim_phase = cft_pkg::PH_FIRST;
			return trim_result(cft_pkg::WIPER_MID > cft_pkg::WIPER_LOW
				&& cft_pkg::WIPER_MID < cft_pkg::WIPER_HIGH, trim_pos, cft_pkg::ST_AWAIT);
		end
		if (trim_phase == cft_pkg::PH_IDLE)
			return trim_result(1'b0, trim_pos, cft_pkg::ST_IGNORED);
		if (!ok) begin
			trim_phase = cft_pkg::PH_IDLE;
			return trim_result(1'b0, trim_pos, cft_pkg::ST_READ_ERR);
		end
		dev = longint'(cur) - longint'(cfg_target);
		if (dev < 0)
			dev = -dev;
		if (dev <= longint'(cfg_tol)) begin
			trim_phase = cft_pkg::PH_IDLE;
			return trim_result(1'b0, trim_pos, cft_pkg::ST_WITHIN);
		end
		// first reading after mid-scale never counts as an overshoot
		if (trim_phase == cft_pkg::PH_MOVED) begin
			over = trim_up ? (cur >= cfg_target) : (cur <= cfg_target);
			if (over && trim_sel < 3)
				trim_sel++;
		end
		up = cur < cfg_target;
		while (trim_sel < 3) begin
			nxt = int'(trim_pos) + (up ? TRIM_STEP[trim_sel] : -TRIM_STEP[trim_sel]);
			// landing on either end stop means try the next finer step
			if (nxt <= cft_pkg::WIPER_LOW || nxt >= cft_pkg::WIPER_HIGH)
				trim_sel++;
			else begin
				trim_pos = cft_pkg::WIPER_W'(nxt);
				trim_up = up;
				trim_phase = cft_pkg::PH_MOVED;
				return trim_result(1'b1, trim_pos, cft_pkg::ST_AWAIT);
			end
		end
		trim_phase = cft_pkg::PH_IDLE;
		return trim_result(1'b0, trim_pos, cft_pkg::ST_EXHAUSTED);
	endfunction

	// Register write with a setup and an access phase; the model copy follows at the access edge
	task automatic reg_write(input cft_pkg::reg_idx_t idx,
			input logic [cft_pkg::PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == cft_pkg::REG_TARGET)
			cfg_target = val[cft_pkg::CURRENT_W-1:0];
		else
			cfg_tol = val[cft_pkg::TOL_W-1:0];
	endtask

	// Offers one item, waits for it to be taken, then logs what it should give.
	// A typed row carries its own result; the model copy still steps.
	task automatic send_item(input logic md, input logic [cft_pkg::CURRENT_W-1:0] cur,
			input logic ok, input bit typed, input cft_pkg::result_t typed_res);
		cft_pkg::result_t r;
		if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		measured_current <= cur;
		reading_ok <= ok;
		do @(posedge clk); while (in_stall);
		r = trim_next(md, cur, ok);
		if (r.status != cft_pkg::ST_IGNORED)
			n_items++;
		trim_exp.push_back(typed ? typed_res : r);
	endtask

	// One well-formed search against a simple plant: current rises linearly with
	// the wiper and crosses the target near w_star, plus a little noise.
	task automatic run_search();
		int     w_star;
		int     gain;
		int     guard;
		longint c;
		send_item(cft_pkg::MODE_START, cft_pkg::CURRENT_W'($urandom()), 1'($urandom()),
			1'b0, '0);
		w_star = $urandom_range(1, 255);
		gain = $urandom_range(1, 3000);
		guard = 0;
		while (trim_phase != cft_pkg::PH_IDLE && guard < 40) begin
			c = longint'(cfg_target) + longint'(int'(trim_pos) - w_star) * gain
				+ longint'($urandom_range(0, gain)) - gain / 2;
			if (c > CUR_HI)
				c = CUR_HI;
			else if (c < CUR_LO)
				c = CUR_LO;
			// now and then a failed read cuts the search short
			send_item(cft_pkg::MODE_MEASURE, cft_pkg::CURRENT_W'(c),
				$urandom_range(0, 39) != 0, 1'b0, '0);
			guard++;
		end
	endtask

	// Parks the input and waits until every logged result has come back.
	// Every item gives a result, so nothing can still be in flight after that.
	task automatic drain();
		in_valid <= 1'b0;
		while (trim_exp.size() != 0)
			@(posedge clk);
	endtask

	// Result stall: random bursts while idling is on
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (gap_odds != 0 && stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
				stall_left = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				stall_left = 0;
				out_stall <= 1'b0;
			end
		end
	end

	// Result check: every result taken is held against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (trim_exp.size() == 0) begin
				$error("result with nothing expected: write_wiper %0d wiper_value %0d status %0d",
					write_wiper, wiper_value, status);
				errs++;
			end else begin
				want = trim_exp.pop_front();
				if (write_wiper !== want.write_wiper) begin
					$error("write_wiper: expected %0d, got %0d", want.write_wiper, write_wiper);
					errs++;
				end
				if (wiper_value !== want.wiper_value) begin
					$error("wiper_value: expected %0d, got %0d", want.wiper_value, wiper_value);
					errs++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errs++;
				end
			end
		end
	end

	// Hard stop far beyond the slowest legal run
	initial begin
		#5000000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int i;
		int p;
		int k;
		logic [cft_pkg::PDATA_W-1:0] tgt_val;
		logic [cft_pkg::PDATA_W-1:0] tol_val;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = cft_pkg::MODE_START;
		measured_current = '0;
		reading_ok = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// Directed items. Typed rows are the obvious ones: starts, ignored
		// measurements, read errors and an in-tolerance first reading.
		dir_tab = '{
			// measurement straight out of reset is ignored
			row(cft_pkg::MODE_MEASURE, '0, 1'b1, 1'b1, 1'b0, 9'd128, cft_pkg::ST_IGNORED),
			// start ignores the current and the reading flag
			row(cft_pkg::MODE_START, CUR_MIN, 1'b0, 1'b1, 1'b1, 9'd128, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, TGT_DIR, 1'b0, 1'b1, 1'b0, 9'd128,
				cft_pkg::ST_READ_ERR),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b1, 1'b0, 9'd128,
				cft_pkg::ST_IGNORED),
			row(cft_pkg::MODE_START, CUR_MAX, 1'b1, 1'b1, 1'b1, 9'd128, cft_pkg::ST_AWAIT),
			// first reading sits right on the tolerance edge
			row(cft_pkg::MODE_MEASURE, TGT_DIR + TOL_DIR, 1'b1, 1'b1, 1'b0, 9'd128,
				cft_pkg::ST_WITHIN),
			row(cft_pkg::MODE_START, '0, 1'b0, 1'b1, 1'b1, 9'd128, cft_pkg::ST_AWAIT),
			// climb, hit the top stop with the coarse step, fall back to 10
			row(cft_pkg::MODE_MEASURE, CUR_MIN, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MIN, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			// start in the middle of a search
			row(cft_pkg::MODE_START, CUR_MIN, 1'b1, 1'b1, 1'b1, 9'd128, cft_pkg::ST_AWAIT),
			// back and forth: overshoots refine the step
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MIN, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			// one LSB outside the tolerance
			row(cft_pkg::MODE_MEASURE, TGT_DIR + TOL_DIR + 24'd1, 1'b1, 1'b0, 1'b0, '0,
				cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_START, '0, 1'b1, 1'b1, 1'b1, 9'd128, cft_pkg::ST_AWAIT),
			// walk down to the bottom stop until no step is left
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT),
			row(cft_pkg::MODE_MEASURE, CUR_MAX, 1'b1, 1'b0, 1'b0, '0, cft_pkg::ST_AWAIT)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds = 4;
		reg_write(cft_pkg::REG_TARGET, cft_pkg::PDATA_W'(TGT_DIR));
		reg_write(cft_pkg::REG_TOLERANCE, cft_pkg::PDATA_W'(TOL_DIR));
		for (i = 0; i < DIR_N; i++)
			send_item(dir_tab[i].md, dir_tab[i].cur, dir_tab[i].ok, dir_tab[i].typed,
				dir_tab[i].want);

		// Random part: one register setting per phase, extremes included.
		// Idling odds change per phase; the last phase runs flat out.
		n_items = 0;
		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				1: begin
					tgt_val = cft_pkg::PDATA_W'(CUR_MIN);
					tol_val = '0;
				end
				2: begin
					tgt_val = cft_pkg::PDATA_W'(CUR_MAX);
					tol_val = cft_pkg::PDATA_W'(23'h7FFFFF);
				end
				3: begin
					tgt_val = cft_pkg::PDATA_W'(cft_pkg::CURRENT_W'($urandom()));
					tol_val = $urandom_range(0, 3000);
				end
				4: begin
					tgt_val = cft_pkg::PDATA_W'($urandom_range(0, 65535)) - 32'd32768;
					tol_val = '0;
				end
				5: begin
					tgt_val = cft_pkg::PDATA_W'(cft_pkg::CURRENT_W'($urandom()));
					tol_val = cft_pkg::PDATA_W'(cft_pkg::TOL_W'($urandom()));
				end
				default: begin
					tgt_val = cft_pkg::PDATA_W'($urandom_range(0, 65535)) - 32'd32768;
					tol_val = $urandom_range(0, 2000);
				end
			endcase
			reg_write(cft_pkg::REG_TARGET, tgt_val);
			reg_write(cft_pkg::REG_TOLERANCE, tol_val);
			gap_odds = GAP_ODDS[p];
			while (n_items < (p + 1) * ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) != 0)
					run_search();
				else begin
					// loose items: stray measurements, stray starts, bad reads
					for (k = $urandom_range(1, 5); k > 0; k--)
						send_item($urandom_range(0, 3) != 0, cft_pkg::CURRENT_W'($urandom()),
							1'($urandom()), 1'b0, '0);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
